### sv/bgr_pkg.sv
// Shared types, constants and tables for the glide ratio field selector.
package bgr_pkg;

   // Table geometry
   localparam int MaxFields = 64;
   localparam int FieldAw   = $clog2(MaxFields);
   localparam int FieldsW   = 7;

   // Iteration counts of the shared units
   localparam int SqrtSteps   = 32;
   localparam int DivSteps    = 54;
   localparam int CordicSteps = 20;
   localparam int CordicShift = 16;

   // Datapath widths
   localparam int DistW = 46;   // distance in 2.5e-6 m units
   localparam int DvW   = 34;   // divisor
   localparam int NumW  = 54;   // dividend and quotient
   localparam int RatW  = 36;   // unclamped ratio
   localparam int CorW  = 50;   // rotator vector
   localparam int ZW    = 24;   // rotator angle in 1e-4 deg

   // Arithmetic constants
   localparam int DistUnit   = 11112;
   localparam int DistDiv    = 400000;
   localparam int CdegHalf   = 50;
   localparam int Deg180     = 1800000;
   localparam int Bearing90  = 9000;
   localparam int AngClamp   = 18000;
   localparam int RatioClamp = 25344;
   localparam int DistMax    = 67108863;

   // Reciprocals: (D >> 7) * ceil(2^51 / 3125) >> 51 gives D / 400000,
   // split into high and low 20-bit halves; z * ceil(2^32 / 100) >> 32 gives z / 100
   localparam int DistRecHi = 687194;
   localparam int DistRecLo = 804636;
   localparam int CdegRec   = 42949673;

   // Item operations
   localparam logic OpLoad  = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef enum logic [4:0] {
      DpNop, DpLoad, DpQuery, DpRead, DpDiff, DpSqa, DpSqo, DpSqrt, DpMul,
      DpDivRatio, DpDivStep, DpCmp, DpDistLo, DpDist, DpCinit, DpCstep,
      DpAngle, DpResult
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [FieldAw-1:0] addr;
      logic [4:0]         step;
   } dp_cmd_type;

   typedef struct packed {
      logic found;
      logic h_pos;
      logic zero_vec;
   } dp_status_type;

   typedef struct packed {
      logic               operation;
      logic [5:0]         entry_index;
      logic signed [27:0] latitude;
      logic signed [28:0] longitude;
      logic signed [14:0] altitude;
   } req_item_type;

   typedef struct packed {
      logic               found;
      logic [5:0]         field_index;
      logic [14:0]        glide_ratio_q8;
      logic [25:0]        distance_m;
      logic signed [15:0] bearing_cdeg;
   } rsp_item_type;

   // atan(2^-i) in 1e-4 degree
   function automatic logic [18:0] atan_tab(input logic [4:0] i);
      logic [18:0] v;
      case (i)
         5'd0:    v = 19'd450000;
         5'd1:    v = 19'd265651;
         5'd2:    v = 19'd140362;
         5'd3:    v = 19'd71250;
         5'd4:    v = 19'd35763;
         5'd5:    v = 19'd17899;
         5'd6:    v = 19'd8952;
         5'd7:    v = 19'd4476;
         5'd8:    v = 19'd2238;
         5'd9:    v = 19'd1119;
         5'd10:   v = 19'd560;
         5'd11:   v = 19'd280;
         5'd12:   v = 19'd140;
         5'd13:   v = 19'd70;
         5'd14:   v = 19'd35;
         5'd15:   v = 19'd17;
         5'd16:   v = 19'd9;
         5'd17:   v = 19'd4;
         5'd18:   v = 19'd2;
         5'd19:   v = 19'd1;
         default: v = 19'd0;
      endcase
      return v;
   endfunction

endpackage

### sv/bgr_req_if.sv
// Request channel: valid/ready with load or query payload.
interface bgr_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [5:0]         entry_index;
   logic signed [27:0] latitude;
   logic signed [28:0] longitude;
   logic signed [14:0] altitude;

   modport source (output valid, operation, entry_index, latitude, longitude, altitude,
                   input ready);
   modport sink (input valid, operation, entry_index, latitude, longitude, altitude,
                 output ready);
endinterface

### sv/bgr_rsp_if.sv
// Response channel: valid/ready with best field result.
interface bgr_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [5:0]         field_index;
   logic [14:0]        glide_ratio_q8;
   logic [25:0]        distance_m;
   logic signed [15:0] bearing_cdeg;

   modport source (output valid, found, field_index, glide_ratio_q8, distance_m,
                   bearing_cdeg, input ready);
   modport sink (input valid, found, field_index, glide_ratio_q8, distance_m,
                 bearing_cdeg, output ready);
endinterface

### sv/bgr_csr_if.sv
// Register write channel: valid/ready with field count data.
interface bgr_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### sv/best_glide_ratio_field_select.sv
// A query scans the N fields in use; each field below the current altitude passes through
// the 32-step square root and the 54-step ratio divider, and the rotator is skipped when
// the best field sits at the current position.
// One item at a time; the next request is taken while a response waits for transfer.
// Synchronous reset clears control and the field count; the table holds no reset value.
module best_glide_ratio_field_select import bgr_pkg::*; (
   input logic      clock,
   input logic      reset,
   bgr_req_if.sink  req_bus,
   bgr_rsp_if.source rsp_bus,
   bgr_csr_if.sink  csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;

   // Gather request payload
   assign req_item.operation   = req_bus.operation;
   assign req_item.entry_index = req_bus.entry_index;
   assign req_item.latitude    = req_bus.latitude;
   assign req_item.longitude   = req_bus.longitude;
   assign req_item.altitude    = req_bus.altitude;

   bgr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .csr_valid     (csr_bus.valid),
      .csr_data      (csr_bus.data),
      .csr_ready     (csr_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .cmd           (cmd),
      .status        (status)
   );

   bgr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // Drive response payload
   assign rsp_bus.found          = rsp_item.found;
   assign rsp_bus.field_index    = rsp_item.field_index;
   assign rsp_bus.glide_ratio_q8 = rsp_item.glide_ratio_q8;
   assign rsp_bus.distance_m     = rsp_item.distance_m;
   assign rsp_bus.bearing_cdeg   = rsp_item.bearing_cdeg;

endmodule

### sv/bgr_datapath.sv
// Field table, distance, ratio, divider, rotator and result register.
module bgr_datapath import bgr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_item_type  req_item,
   output dp_status_type status,
   output rsp_item_type  rsp_item
);

   logic signed [27:0] mem_lat [MaxFields];
   logic signed [28:0] mem_lon [MaxFields];
   logic signed [14:0] mem_alt [MaxFields];

   logic signed [27:0] rd_lat_ff, pos_lat_ff;
   logic signed [28:0] rd_lon_ff, pos_lon_ff;
   logic signed [14:0] rd_alt_ff, pos_alt_ff;
   logic signed [28:0] dlat_ff, best_dlat_ff;
   logic signed [29:0] dlon_ff, best_dlon_ff;
   logic signed [15:0] h_ff;
   logic [55:0]        sqa_ff;
   logic [63:0]        v_ff, r_ff, b_ff;
   logic [DistW-1:0]   d_ff, best_d_ff;
   logic [DvW-1:0]     dv_ff, div_ff, rem_ff;
   logic [NumW-1:0]    num_ff, quo_ff;
   logic               found_ff;
   logic [FieldAw-1:0] best_idx_ff;
   logic [RatW-1:0]    best_ratio_ff;
   logic [25:0]        dist_ff;
   logic [38:0]        dlo_ff;
   logic [18:0]        cdeg_ff;
   logic signed [CorW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0]   z_ff;
   rsp_item_type       rsp_ff;

   logic signed [28:0] dlat_in;
   logic signed [29:0] dlon_in;
   logic signed [15:0] h_in;
   logic signed [57:0] sq_lat;
   logic signed [59:0] sq_lon;
   logic [58:0]        sum_sq;
   logic [63:0]        rb;
   logic               sqrt_ge;
   logic [DistW-1:0]   d_prod;
   logic [DvW-1:0]     dv_prod;
   logic [DvW:0]       trial, trial_diff;
   logic               div_ge;
   logic [RatW-1:0]    ratio;
   logic [38:0]        dist_x;
   logic [58:0]        dist_lo_prod, dist_hi_prod;
   logic [59:0]        dist_sum;
   logic [25:0]        dist_sat;
   logic signed [CorW-1:0] ix, iy, xs, ys;
   logic [ZW-1:0]      zmag;
   logic [ZW:0]        zround;
   logic [50:0]        ang_prod;
   logic [14:0]        cabs;
   logic signed [15:0] cval, bearing;
   logic [14:0]        ratio_clamped;

   // Differences against current position
   assign dlat_in = 29'(rd_lat_ff) - 29'(pos_lat_ff);
   assign dlon_in = 30'(rd_lon_ff) - 30'(pos_lon_ff);
   assign h_in    = 16'(pos_alt_ff) - 16'(rd_alt_ff);

   // Squares and sum
   assign sq_lat = dlat_ff * dlat_ff;
   assign sq_lon = dlon_ff * dlon_ff;
   assign sum_sq = {3'b0, sqa_ff} + sq_lon[58:0];

   // Square root step
   assign rb      = r_ff + b_ff;
   assign sqrt_ge = v_ff >= rb;

   // Scale root to distance units, build ratio divisor
   assign d_prod  = DistW'(r_ff[31:0]) * DistW'(DistUnit);
   assign dv_prod = DvW'(h_ff[14:0]) * DvW'(DistDiv);

   // Restoring divider step
   assign trial      = {rem_ff, num_ff[NumW-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign div_ge     = trial >= {1'b0, div_ff};

   assign ratio = quo_ff[RatW-1:0];

   // Distance in metres by reciprocal multiply, low half first, then saturate
   assign dist_x       = best_d_ff[DistW-1:7];
   assign dist_lo_prod = 59'(dist_x) * 59'(DistRecLo);
   assign dist_hi_prod = 59'(dist_x) * 59'(DistRecHi);
   assign dist_sum     = 60'(dist_hi_prod) + 60'(dlo_ff);
   assign dist_sat     = (dist_sum[59:57] != '0) ? 26'(DistMax) : dist_sum[56:31];

   // Rotator operands
   assign ix = {{4{best_dlon_ff[29]}}, best_dlon_ff, 16'b0};
   assign iy = {{5{best_dlat_ff[28]}}, best_dlat_ff, 16'b0};
   assign xs = cx_ff >>> cmd.step;
   assign ys = cy_ff >>> cmd.step;

   // Angle rounding to centidegrees and bearing
   assign zmag     = z_ff[ZW-1] ? ZW'(-z_ff) : z_ff;
   assign zround   = (ZW+1)'(zmag) + (ZW+1)'(CdegHalf);
   assign ang_prod = 51'(zround) * 51'(CdegRec);
   assign cabs     = (cdeg_ff > 19'(AngClamp)) ? 15'(AngClamp) : cdeg_ff[14:0];
   assign cval     = z_ff[ZW-1] ? -16'(cabs) : 16'(cabs);
   assign bearing  = 16'(Bearing90) - cval;
   assign ratio_clamped = (best_ratio_ff > RatW'(RatioClamp)) ?
                          15'(RatioClamp) : best_ratio_ff[14:0];

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.op == DpLoad) begin
         mem_lat[req_item.entry_index[FieldAw-1:0]] <= req_item.latitude;
         mem_lon[req_item.entry_index[FieldAw-1:0]] <= req_item.longitude;
         mem_alt[req_item.entry_index[FieldAw-1:0]] <= req_item.altitude;
      end
      if (cmd.op == DpRead) begin
         rd_lat_ff <= mem_lat[cmd.addr];
         rd_lon_ff <= mem_lon[cmd.addr];
         rd_alt_ff <= mem_alt[cmd.addr];
      end
   end

   // Found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.op == DpQuery) begin
         found_ff <= 1'b0;
      end else if (cmd.op == DpCmp) begin
         found_ff <= 1'b1;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         DpQuery: begin
            pos_lat_ff <= req_item.latitude;
            pos_lon_ff <= req_item.longitude;
            pos_alt_ff <= req_item.altitude;
         end
         DpDiff: begin
            dlat_ff <= dlat_in;
            dlon_ff <= dlon_in;
            h_ff    <= h_in;
         end
         DpSqa: begin
            sqa_ff <= sq_lat[55:0];
         end
         DpSqo: begin
            v_ff <= {1'b0, sum_sq, 4'b0};
            r_ff <= '0;
            b_ff <= 64'h4000_0000_0000_0000;
         end
         DpSqrt: begin
            if (sqrt_ge) begin
               v_ff <= v_ff - rb;
               r_ff <= (r_ff >> 1) + b_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            b_ff <= b_ff >> 2;
         end
         DpMul: begin
            d_ff  <= d_prod;
            dv_ff <= dv_prod;
         end
         DpDivRatio: begin
            num_ff <= {d_ff, 8'b0};
            div_ff <= dv_ff;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         DpDivStep: begin
            rem_ff <= div_ge ? trial_diff[DvW-1:0] : trial[DvW-1:0];
            quo_ff <= {quo_ff[NumW-2:0], div_ge};
            num_ff <= {num_ff[NumW-2:0], 1'b0};
         end
         DpCmp: begin
            if (!found_ff || ratio < best_ratio_ff) begin
               best_idx_ff   <= cmd.addr;
               best_ratio_ff <= ratio;
               best_d_ff     <= d_ff;
               best_dlat_ff  <= dlat_ff;
               best_dlon_ff  <= dlon_ff;
            end
         end
         DpDistLo: begin
            dlo_ff <= dist_lo_prod[58:20];
         end
         DpDist: begin
            dist_ff <= dist_sat;
         end
         DpCinit: begin
            if (best_dlon_ff < 0) begin
               cx_ff <= -ix;
               cy_ff <= -iy;
               z_ff  <= (best_dlat_ff >= 0) ? ZW'(Deg180) : -ZW'(Deg180);
            end else begin
               cx_ff <= ix;
               cy_ff <= iy;
               z_ff  <= '0;
            end
         end
         DpCstep: begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff  <= z_ff + ZW'(atan_tab(cmd.step));
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff  <= z_ff - ZW'(atan_tab(cmd.step));
            end
         end
         DpAngle: begin
            cdeg_ff <= ang_prod[50:32];
         end
         DpResult: begin
            if (found_ff) begin
               rsp_ff.found          <= 1'b1;
               rsp_ff.field_index    <= 6'(best_idx_ff);
               rsp_ff.glide_ratio_q8 <= ratio_clamped;
               rsp_ff.distance_m     <= dist_ff;
               rsp_ff.bearing_cdeg   <= bearing;
            end else begin
               rsp_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign status.found    = found_ff;
   assign status.h_pos    = !h_ff[15] && (h_ff != '0);
   assign status.zero_vec = (best_dlat_ff == '0) && (best_dlon_ff == '0);
   assign rsp_item        = rsp_ff;

endmodule

### sv/bgr_ctrl.sv
// Sequencer: handshakes, field count register, scan and unit iteration control.
module bgr_ctrl import bgr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_operation,
   output logic          req_ready,
   input  logic          csr_valid,
   input  logic [6:0]    csr_data,
   output logic          csr_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      StIdle, StRead, StDiff, StSqa, StSqo, StSqrt, StMul, StDivR, StDivRS, StCmp,
      StNext, StDistLo, StDist, StCinit, StCstep, StAng, StFin
   } state_type;

   state_type          state_ff, state_in;
   logic [FieldsW-1:0] fields_ff;
   logic [FieldsW-1:0] entry_ff, entry_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FieldsW-1:0] nlim;
   logic               req_xfer, out_free;

   assign nlim      = (fields_ff > FieldsW'(MaxFields)) ? FieldsW'(MaxFields) : fields_ff;
   assign req_ready = (state_ff == StIdle);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DpNop;
      cmd.addr     = entry_ff[FieldAw-1:0];
      cmd.step     = cnt_ff[4:0];
      case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               if (req_operation == OpLoad) begin
                  cmd.op = DpLoad;
               end else begin
                  cmd.op   = DpQuery;
                  entry_in = '0;
                  state_in = (nlim == '0) ? StFin : StRead;
               end
            end
         end
         StRead: begin
            cmd.op   = DpRead;
            state_in = StDiff;
         end
         StDiff: begin
            cmd.op   = DpDiff;
            state_in = StSqa;
         end
         StSqa: begin
            if (status.h_pos) begin
               cmd.op   = DpSqa;
               state_in = StSqo;
            end else begin
               state_in = StNext;
            end
         end
         StSqo: begin
            cmd.op   = DpSqo;
            cnt_in   = '0;
            state_in = StSqrt;
         end
         StSqrt: begin
            cmd.op = DpSqrt;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SqrtSteps - 1)) begin
               state_in = StMul;
            end
         end
         StMul: begin
            cmd.op   = DpMul;
            state_in = StDivR;
         end
         StDivR: begin
            cmd.op   = DpDivRatio;
            cnt_in   = '0;
            state_in = StDivRS;
         end
         StDivRS: begin
            cmd.op = DpDivStep;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DivSteps - 1)) begin
               state_in = StCmp;
            end
         end
         StCmp: begin
            cmd.op   = DpCmp;
            state_in = StNext;
         end
         StNext: begin
            entry_in = entry_ff + 7'd1;
            if (entry_ff + 7'd1 == nlim) begin
               state_in = status.found ? StDistLo : StFin;
            end else begin
               state_in = StRead;
            end
         end
         StDistLo: begin
            cmd.op   = DpDistLo;
            state_in = StDist;
         end
         StDist: begin
            cmd.op   = DpDist;
            state_in = StCinit;
         end
         StCinit: begin
            cmd.op   = DpCinit;
            cnt_in   = '0;
            state_in = status.zero_vec ? StAng : StCstep;
         end
         StCstep: begin
            cmd.op = DpCstep;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CordicSteps - 1)) begin
               state_in = StAng;
            end
         end
         StAng: begin
            cmd.op   = DpAngle;
            state_in = StFin;
         end
         StFin: begin
            if (out_free) begin
               cmd.op       = DpResult;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Hold state, counters, field count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         entry_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fields_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            fields_ff <= csr_data;
         end
      end
   end

endmodule
